### hdl/ppm_pkg.sv
`default_nettype none

package ppm_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BRAKE_MIN   = 3'd0,
    REG_BRAKE_MAX   = 3'd1,
    REG_PEDAL_UPPER = 3'd2,
    REG_PEDAL_DIFF  = 3'd3,
    REG_PERSIST     = 3'd4
  } reg_index_t;

  localparam logic [11:0] BrakeMinReset   = 12'd372;
  localparam logic [11:0] BrakeMaxReset   = 12'd1613;
  localparam logic [14:0] PedalUpperReset = 15'd28160;
  localparam logic [15:0] PedalDiffReset  = 16'd5120;
  localparam logic [15:0] PersistReset    = 16'd100;

  typedef struct packed {
    logic signed [15:0] pedal_a_percent;
    logic signed [15:0] pedal_b_percent;
    logic [11:0]        brake_code;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic pedal_instant_fault;
    logic pedal_persist_fault;
    logic brake_instant_fault;
    logic brake_persist_fault;
  } result_t;

  typedef struct packed {
    logic [11:0] brake_min_code;
    logic [11:0] brake_max_code;
    logic [14:0] pedal_upper_limit;
    logic [15:0] pedal_diff_limit;
    logic [15:0] persist_ms;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/ppm_cfg_regs.sv
`default_nettype none

module ppm_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write_en,
  input  wire logic [ppm_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [ppm_pkg::CfgDataWidth-1:0]   cfg_data,
  output ppm_pkg::cfg_t                           cfg
);
  import ppm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_min_code    <= BrakeMinReset;
      cfg.brake_max_code    <= BrakeMaxReset;
      cfg.pedal_upper_limit <= PedalUpperReset;
      cfg.pedal_diff_limit  <= PedalDiffReset;
      cfg.persist_ms        <= PersistReset;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_BRAKE_MIN:   cfg.brake_min_code    <= cfg_data[11:0];
        REG_BRAKE_MAX:   cfg.brake_max_code    <= cfg_data[11:0];
        REG_PEDAL_UPPER: cfg.pedal_upper_limit <= cfg_data[14:0];
        REG_PEDAL_DIFF:  cfg.pedal_diff_limit  <= cfg_data;
        REG_PERSIST:     cfg.persist_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/ppm_sample_check.sv
`default_nettype none

module ppm_sample_check (
  input  wire ppm_pkg::sample_t sample,
  input  wire ppm_pkg::cfg_t    cfg,
  output logic                  pedal_fault,
  output logic                  brake_fault
);
  import ppm_pkg::*;

  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;
  logic signed [16:0] upper_ext;
  logic signed [16:0] diff;
  logic        [16:0] mag;

  always_comb begin
    a_ext     = 17'(sample.pedal_a_percent);
    b_ext     = 17'(sample.pedal_b_percent);
    upper_ext = signed'({2'b00, cfg.pedal_upper_limit});
    diff      = a_ext - b_ext;
    mag       = diff[16] ? 17'(-diff) : 17'(diff);

    pedal_fault = sample.pedal_a_percent[15] || sample.pedal_b_percent[15] ||
                  (a_ext > upper_ext) || (b_ext > upper_ext) ||
                  (mag > {1'b0, cfg.pedal_diff_limit});
    brake_fault = (sample.brake_code < cfg.brake_min_code) ||
                  (sample.brake_code > cfg.brake_max_code);
  end

endmodule

`default_nettype wire

### hdl/ppm_fault_timer.sv
`default_nettype none

module ppm_fault_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        fault,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] persist_ms,
  output logic             persist_fault
);

  logic        timing;
  logic [31:0] start_ms;
  logic [31:0] elapsed;

  // a fresh start gives zero elapsed time
  always_comb begin
    elapsed       = timing ? (now_ms - start_ms) : 32'd0;
    persist_fault = fault && (elapsed >= {16'd0, persist_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timing <= 1'b0;
    end else if (advance) begin
      timing <= fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_ms <= '0;
    end else if (advance && fault && !timing) begin
      start_ms <= now_ms;
    end
  end

endmodule

`default_nettype wire

### hdl/pedal_plausibility_monitor.sv
// Accelerator and brake sensor plausibility monitor. Takes one sample per
// request and returns one result per sample, in order. A sample is registered
// on entry, checked against the limits and the two fault timers, and its
// result lands in the output register when that is free or being taken; a new
// sample is taken every cycle while results are being taken. Persistence is
// measured with 32-bit wrapping subtraction on now_ms. The user must write
// limits through the cfg port only while no sample is in flight; not enforced.
`default_nettype none

module pedal_plausibility_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output logic                                    sample_ready,
  input  wire ppm_pkg::sample_t                   sample,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output ppm_pkg::result_t                        result,
  input  wire logic                               cfg_write_en,
  input  wire logic [ppm_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [ppm_pkg::CfgDataWidth-1:0]   cfg_data
);
  import ppm_pkg::*;

  cfg_t    cfg;
  sample_t held;
  logic    held_valid;
  logic    advance;
  logic    pedal_fault;
  logic    brake_fault;
  logic    pedal_persist;
  logic    brake_persist;
  result_t result_next;

  assign advance      = held_valid && (!result_valid || result_ready);
  assign sample_ready = !held_valid || advance;

  ppm_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  ppm_sample_check u_check (
    .sample      (held),
    .cfg         (cfg),
    .pedal_fault (pedal_fault),
    .brake_fault (brake_fault)
  );

  ppm_fault_timer u_pedal_timer (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .fault         (pedal_fault),
    .now_ms        (held.now_ms),
    .persist_ms    (cfg.persist_ms),
    .persist_fault (pedal_persist)
  );

  ppm_fault_timer u_brake_timer (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .fault         (brake_fault),
    .now_ms        (held.now_ms),
    .persist_ms    (cfg.persist_ms),
    .persist_fault (brake_persist)
  );

  always_comb begin
    result_next.pedal_instant_fault = pedal_fault;
    result_next.pedal_persist_fault = pedal_persist;
    result_next.brake_instant_fault = brake_fault;
    result_next.brake_persist_fault = brake_persist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_ready) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      held <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
